>>> src/ctp_pkg.sv
// Shared types, character codes and helpers for the color tag text parser.
package ctp_pkg;

  localparam int CHAR_W    = 8;
  localparam int COLOR_W   = 16;
  localparam int RGB_W     = 24;
  localparam int NIB_W     = 4;
  localparam int CFG_IDX_W = 1;

  localparam logic [CHAR_W-1:0] CH_LBRACKET = 8'h5B;
  localparam logic [CHAR_W-1:0] CH_RBRACKET = 8'h5D;
  localparam logic [CHAR_W-1:0] CH_HASH     = 8'h23;

  localparam logic ACT_CHAR  = 1'b0;
  localparam logic ACT_COLOR = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_FOREGROUND = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND = 1'b1;

  localparam logic [COLOR_W-1:0] FG_RESET = 16'hFFFF;
  localparam logic [COLOR_W-1:0] BG_RESET = 16'h0000;

  // Color stack request from the sequencer.
  typedef struct packed {
    logic clear;
    logic pop;
    logic push;
  } stack_cmd_t;

  // Color stack answer to a pop.
  typedef struct packed {
    logic               top_valid;
    logic [COLOR_W-1:0] data;
  } stack_rsp_t;

  // 24-bit RGB to RGB565: keep the top 5/6/5 bits of each channel.
  function automatic logic [COLOR_W-1:0] to_rgb565(input logic [RGB_W-1:0] rgb);
    to_rgb565 = {rgb[23:19], rgb[15:10], rgb[7:3]};
  endfunction

endpackage

>>> src/ctp_if.sv
// Valid/ready channel interfaces: text bytes in, actions out, register writes.
interface ctp_in_if;
  logic                      valid;
  logic                      ready;
  logic [ctp_pkg::CHAR_W-1:0] ch;
  logic                      first;
  logic                      markup;

  modport source (output valid, output ch, output first, output markup, input ready);
  modport sink   (input valid, input ch, input first, input markup, output ready);
endinterface

interface ctp_out_if;
  logic                       valid;
  logic                       ready;
  logic                       action;
  logic [ctp_pkg::CHAR_W-1:0]  char_out;
  logic [ctp_pkg::COLOR_W-1:0] text_color;
  logic [ctp_pkg::COLOR_W-1:0] back_color;
  logic                       last;

  modport source (output valid, output action, output char_out, output text_color,
                  output back_color, output last, input ready);
  modport sink   (input valid, input action, input char_out, input text_color,
                  input back_color, input last, output ready);
endinterface

interface ctp_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [ctp_pkg::CFG_IDX_W-1:0] index;
  logic [ctp_pkg::COLOR_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> src/color_tag_text_parser.sv
// Top level of the color tag text parser: config registers, sequencer, color stack.
//
// Takes one text byte per transaction and returns zero to nine action transactions:
// print a character, or set the text colors (RGB565 foreground plus the configured
// background). With markup set, "[#RRGGBB]" selects and pushes a color, "[]" pops,
// "[#]" empties the stack and selects the foreground register, "[[" prints "[", and a
// malformed tag echoes the held characters; with markup clear bytes print raw and the
// parser and stack are cleared. "first" clears everything and, with markup set,
// emits a color reset. The byte is latched in S_IDLE and decoded in S_DEC; a closing
// "]" of a color then passes each held digit through the shared hex decoder in
// S_CONV to build the 24-bit value. Results leave one per cycle, while the sink does
// not stall, through a single output register, and the input is not ready until the
// byte's last result is loaded. A byte with no result (opening bracket, hash, a stored
// digit) goes from S_DEC straight back to S_IDLE. The color stack is a circular
// buffer of STACK_DEPTH entries; pushing onto a full stack overwrites the oldest
// entry. Register writes go through the cfg channel (index 0 foreground, 1
// background) and are always accepted.
module color_tag_text_parser #(
  parameter int STACK_DEPTH    = 16,
  parameter int MAX_HEX_DIGITS = 6
) (
  input  logic      clk,
  input  logic      rst,
  ctp_in_if.sink    text,
  ctp_out_if.source result,
  ctp_cfg_if.sink   cfg
);
  import ctp_pkg::*;

  logic [COLOR_W-1:0] fg;
  logic [COLOR_W-1:0] bg;
  stack_cmd_t         stk_cmd;
  stack_rsp_t         stk_rsp;
  logic [COLOR_W-1:0] stk_wdata;

  // register writes are never stalled
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fg <= FG_RESET;
      bg <= BG_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_FOREGROUND: fg <= cfg.data;
        REG_BACKGROUND: bg <= cfg.data;
        default: ;
      endcase
    end
  end

  // sequencer: parser state, digit store, shared hex unit, output register
  ctp_engine #(
    .MAX_HEX_DIGITS (MAX_HEX_DIGITS)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .text      (text),
    .result    (result),
    .fg        (fg),
    .bg        (bg),
    .stk_cmd   (stk_cmd),
    .stk_wdata (stk_wdata),
    .stk_rsp   (stk_rsp)
  );

  // color stack memory, registered read of the new top on a pop
  ctp_stack #(
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .rst   (rst),
    .cmd   (stk_cmd),
    .wdata (stk_wdata),
    .rsp   (stk_rsp)
  );

endmodule

>>> src/ctp_hex_unit.sv
// Shared hex digit decoder: ASCII byte to nibble value plus a hit flag.
module ctp_hex_unit (
  input  logic [ctp_pkg::CHAR_W-1:0] code,
  output logic                       hit,
  output logic [ctp_pkg::NIB_W-1:0]  nib
);
  import ctp_pkg::*;

  localparam logic [CHAR_W-1:0] CH_0  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UA = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UF = 8'h46;
  localparam logic [CHAR_W-1:0] CH_LA = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LF = 8'h66;

  logic is_dec;
  logic is_alpha;

  assign is_dec   = (code >= CH_0) && (code <= CH_9);
  assign is_alpha = ((code >= CH_UA) && (code <= CH_UF)) ||
                    ((code >= CH_LA) && (code <= CH_LF));
  assign hit      = is_dec || is_alpha;
  // letters a..f / A..F have low nibble 1..6, value is that plus 9
  assign nib      = is_alpha ? (code[NIB_W-1:0] + 4'd9) : code[NIB_W-1:0];

endmodule

>>> src/ctp_stack.sv
// Bounded color stack: circular buffer, oldest entry overwritten when full.
module ctp_stack #(
  parameter int DEPTH = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  ctp_pkg::stack_cmd_t         cmd,
  input  logic [ctp_pkg::COLOR_W-1:0] wdata,
  output ctp_pkg::stack_rsp_t         rsp
);
  import ctp_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW = CW + 1;

  logic [COLOR_W-1:0] mem [DEPTH];
  logic [CW-1:0]      cnt;
  logic [PW-1:0]      base;
  logic [CW-1:0]      cnt_eff;
  logic [CW-1:0]      cnt_new;
  logic [CW-1:0]      rd_off;
  logic [SW-1:0]      rd_sum;
  logic [SW-1:0]      rd_wrap;
  logic [SW-1:0]      wr_sum;
  logic [SW-1:0]      wr_wrap;
  logic [PW-1:0]      base_inc;
  logic               full;
  logic               top_valid;
  logic [COLOR_W-1:0] top_data;

  assign rsp.top_valid = top_valid;
  assign rsp.data      = top_data;

  always_comb begin
    cnt_eff  = cmd.clear ? '0 : cnt;
    cnt_new  = (cnt_eff != '0) ? (cnt_eff - CW'(1)) : '0;
    rd_off   = (cnt_new != '0) ? (cnt_new - CW'(1)) : '0;
    rd_sum   = SW'(base) + SW'(rd_off);
    rd_wrap  = (rd_sum >= SW'(DEPTH)) ? (rd_sum - SW'(DEPTH)) : rd_sum;
    full     = (cnt == CW'(DEPTH));
    // full: the new entry lands on the oldest slot
    wr_sum   = full ? SW'(base) : (SW'(base) + SW'(cnt));
    wr_wrap  = (wr_sum >= SW'(DEPTH)) ? (wr_sum - SW'(DEPTH)) : wr_sum;
    base_inc = (base == PW'(DEPTH - 1)) ? '0 : (base + PW'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      base      <= '0;
      top_valid <= 1'b0;
    end else begin
      if (cmd.pop) begin
        cnt       <= cnt_new;
        top_valid <= (cnt_new != '0);
      end else if (cmd.clear) begin
        cnt <= '0;
      end
      if (cmd.push) begin
        if (full) begin
          base <= base_inc;
        end else begin
          cnt <= cnt + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[wr_wrap[PW-1:0]] <= wdata;
    end
    if (cmd.pop) begin
      top_data <= mem[rd_wrap[PW-1:0]];
    end
  end

endmodule

>>> src/ctp_engine.sv
// Tag parsing sequencer: decode, hex accumulation, result emission.
module ctp_engine #(
  parameter int MAX_HEX_DIGITS = 6
) (
  input  logic                        clk,
  input  logic                        rst,
  ctp_in_if.sink                      text,
  ctp_out_if.source                   result,
  input  logic [ctp_pkg::COLOR_W-1:0] fg,
  input  logic [ctp_pkg::COLOR_W-1:0] bg,
  output ctp_pkg::stack_cmd_t         stk_cmd,
  output logic [ctp_pkg::COLOR_W-1:0] stk_wdata,
  input  ctp_pkg::stack_rsp_t         stk_rsp
);
  import ctp_pkg::*;

  localparam int CNTW = $clog2(MAX_HEX_DIGITS + 1);
  localparam int IDXW = (MAX_HEX_DIGITS > 1) ? $clog2(MAX_HEX_DIGITS) : 1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DEC  = 4'b0010,
    S_CONV = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  // latched transaction
  logic [CHAR_W-1:0] ch_r;
  logic              first_r;
  logic              markup_r;

  // parser state
  logic              in_tag;
  logic              hash_seen;
  logic [CNTW-1:0]   digit_count;
  logic [CHAR_W-1:0] hex_digits [MAX_HEX_DIGITS];

  // pending results of the current byte
  logic              pend_first;
  logic              pend_lbr;
  logic              pend_hash;
  logic              pend_ch;
  logic              pend_col;
  logic [CHAR_W-1:0] ch_val;
  logic [CNTW-1:0]   dig_n;
  logic [CNTW-1:0]   dig_idx;
  logic              col_from_stack;
  logic [COLOR_W-1:0] col_reg;
  logic [RGB_W-1:0]  acc;
  logic [RGB_W-1:0]  acc_next;

  // output register
  logic               out_valid;
  logic               out_action;
  logic [CHAR_W-1:0]  out_char;
  logic [COLOR_W-1:0] out_text;
  logic [COLOR_W-1:0] out_back;
  logic               out_last;

  // shared hex unit
  logic [CHAR_W-1:0] hex_in;
  logic              hex_hit;
  logic [NIB_W-1:0]  hex_nib;
  logic [IDXW-1:0]   rd_idx;
  logic [CHAR_W-1:0] dig_rd;

  // decode results
  logic              eff_in_tag;
  logic              eff_hash;
  logic [CNTW-1:0]   eff_dc;
  logic              nx_in_tag;
  logic              nx_hash;
  logic [CNTW-1:0]   nx_dc;
  logic              d_wr;
  logic              d_echo;
  logic              d_lbr;
  logic              d_ch;
  logic [CHAR_W-1:0] d_ch_val;
  logic              d_pop;
  logic              d_col_fg;
  logic              d_conv;
  logic              d_clear;
  logic              d_any;

  // emission
  logic               can_emit;
  logic               dig_pend;
  logic               nf_first;
  logic               nf_lbr;
  logic               nf_hash;
  logic               nf_ch;
  logic               nf_col;
  logic [CNTW-1:0]    nf_idx;
  logic               em_action;
  logic [CHAR_W-1:0]  em_char;
  logic [COLOR_W-1:0] em_text;
  logic [COLOR_W-1:0] em_back;
  logic               em_last;
  logic [COLOR_W-1:0] col_val;
  logic               conv_last;

  assign text.ready        = (state == S_IDLE);
  assign result.valid      = out_valid;
  assign result.action     = out_action;
  assign result.char_out   = out_char;
  assign result.text_color = out_text;
  assign result.back_color = out_back;
  assign result.last       = out_last;

  assign rd_idx   = (dig_idx < CNTW'(MAX_HEX_DIGITS)) ? dig_idx[IDXW-1:0] : '0;
  assign dig_rd   = hex_digits[rd_idx];
  assign hex_in   = (state == S_DEC) ? ch_r : dig_rd;
  assign acc_next = {acc[RGB_W-NIB_W-1:0], hex_nib};

  ctp_hex_unit u_hex (
    .code (hex_in),
    .hit  (hex_hit),
    .nib  (hex_nib)
  );

  // ---- decode of one byte ----
  always_comb begin
    eff_in_tag = in_tag & ~first_r;
    eff_hash   = hash_seen & ~first_r;
    eff_dc     = first_r ? '0 : digit_count;
    nx_in_tag  = eff_in_tag;
    nx_hash    = eff_hash;
    nx_dc      = eff_dc;
    d_wr       = 1'b0;
    d_echo     = 1'b0;
    d_lbr      = 1'b0;
    d_ch       = 1'b0;
    d_ch_val   = ch_r;
    d_pop      = 1'b0;
    d_col_fg   = 1'b0;
    d_conv     = 1'b0;
    d_clear    = 1'b0;
    if (!markup_r) begin
      nx_in_tag = 1'b0;
      nx_hash   = 1'b0;
      nx_dc     = '0;
      d_clear   = 1'b1;
      d_ch      = 1'b1;
    end else begin
      d_clear = first_r;
      if (!eff_in_tag) begin
        if (ch_r == CH_LBRACKET) begin
          nx_in_tag = 1'b1;
          nx_hash   = 1'b0;
          nx_dc     = '0;
        end else begin
          d_ch = 1'b1;
        end
      end else if (!eff_hash) begin
        nx_in_tag = 1'b0;
        nx_hash   = 1'b0;
        nx_dc     = '0;
        priority if (ch_r == CH_LBRACKET) begin
          d_ch     = 1'b1;
          d_ch_val = CH_LBRACKET;
        end else if (ch_r == CH_RBRACKET) begin
          d_pop = 1'b1;
        end else if (ch_r == CH_HASH) begin
          nx_in_tag = 1'b1;
          nx_hash   = 1'b1;
        end else begin
          d_lbr = 1'b1;
          d_ch  = 1'b1;
        end
      end else if (ch_r == CH_LBRACKET) begin
        // ignored inside a color, tag stays open
        nx_in_tag = eff_in_tag;
      end else if (hex_hit && (eff_dc < CNTW'(MAX_HEX_DIGITS))) begin
        d_wr  = 1'b1;
        nx_dc = eff_dc + CNTW'(1);
      end else if (ch_r == CH_RBRACKET) begin
        nx_in_tag = 1'b0;
        nx_hash   = 1'b0;
        nx_dc     = '0;
        if (eff_dc == '0) begin
          d_clear  = 1'b1;
          d_col_fg = 1'b1;
        end else begin
          d_conv = 1'b1;
        end
      end else begin
        // overflow digit or bad byte: echo what was held
        nx_in_tag = 1'b0;
        nx_hash   = 1'b0;
        nx_dc     = '0;
        d_echo    = 1'b1;
        d_lbr     = 1'b1;
        d_ch      = 1'b1;
      end
    end
    d_any = (first_r & markup_r) | d_lbr | d_ch | d_pop | d_col_fg | d_conv;
  end

  // ---- next result selection ----
  always_comb begin
    dig_pend  = (dig_idx < dig_n);
    can_emit  = !out_valid || result.ready;
    col_val   = (col_from_stack && stk_rsp.top_valid) ? stk_rsp.data : col_reg;
    nf_first  = pend_first;
    nf_lbr    = pend_lbr;
    nf_hash   = pend_hash;
    nf_ch     = pend_ch;
    nf_col    = pend_col;
    nf_idx    = dig_idx;
    em_action = ACT_CHAR;
    em_char   = '0;
    em_text   = '0;
    em_back   = '0;
    priority if (pend_first) begin
      nf_first  = 1'b0;
      em_action = ACT_COLOR;
      em_text   = fg;
      em_back   = bg;
    end else if (pend_lbr) begin
      nf_lbr  = 1'b0;
      em_char = CH_LBRACKET;
    end else if (pend_hash) begin
      nf_hash = 1'b0;
      em_char = CH_HASH;
    end else if (dig_pend) begin
      nf_idx  = dig_idx + CNTW'(1);
      em_char = dig_rd;
    end else if (pend_ch) begin
      nf_ch   = 1'b0;
      em_char = ch_val;
    end else begin
      nf_col    = 1'b0;
      em_action = ACT_COLOR;
      em_text   = col_val;
      em_back   = bg;
    end
    em_last = !(nf_first || nf_lbr || nf_hash || (nf_idx < dig_n) || nf_ch || nf_col);
  end

  always_comb begin
    state_next = state;
    conv_last  = (dig_idx + CNTW'(1)) == dig_n;
    unique case (state)
      S_IDLE: if (text.valid) state_next = S_DEC;
      S_DEC: begin
        if (d_conv) begin
          state_next = S_CONV;
        end else if (d_any) begin
          state_next = S_EMIT;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_CONV: if (conv_last) state_next = S_EMIT;
      S_EMIT: if (can_emit && em_last) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    stk_cmd.clear = (state == S_DEC) && d_clear;
    stk_cmd.pop   = (state == S_DEC) && d_pop;
    stk_cmd.push  = (state == S_CONV) && conv_last;
    stk_wdata     = to_rgb565(acc_next);
  end

  // ---- control registers ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      in_tag      <= 1'b0;
      hash_seen   <= 1'b0;
      digit_count <= '0;
      pend_first  <= 1'b0;
      pend_lbr    <= 1'b0;
      pend_hash   <= 1'b0;
      pend_ch     <= 1'b0;
      pend_col    <= 1'b0;
      dig_n       <= '0;
      dig_idx     <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      // load a new result, or drop the one just taken
      if (state == S_EMIT && can_emit) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: ;
        S_DEC: begin
          in_tag      <= nx_in_tag;
          hash_seen   <= nx_hash;
          digit_count <= nx_dc;
          pend_first  <= first_r & markup_r;
          pend_lbr    <= d_lbr;
          pend_hash   <= d_echo;
          pend_ch     <= d_ch;
          pend_col    <= d_pop | d_col_fg | d_conv;
          dig_n       <= (d_echo || d_conv) ? eff_dc : '0;
          dig_idx     <= '0;
        end
        S_CONV: dig_idx <= dig_idx + CNTW'(1);
        S_EMIT: begin
          if (can_emit) begin
            pend_first <= nf_first;
            pend_lbr   <= nf_lbr;
            pend_hash  <= nf_hash;
            pend_ch    <= nf_ch;
            pend_col   <= nf_col;
            dig_idx    <= nf_idx;
          end
        end
        default: ;
      endcase
    end
  end

  // ---- payload registers ----
  always_ff @(posedge clk) begin
    if (state == S_IDLE && text.valid) begin
      ch_r     <= text.ch;
      first_r  <= text.first;
      markup_r <= text.markup;
    end
    if (state == S_DEC) begin
      ch_val         <= d_ch_val;
      col_from_stack <= d_pop;
      col_reg        <= fg;
      acc            <= '0;
      if (d_wr) begin
        hex_digits[eff_dc[IDXW-1:0]] <= ch_r;
      end
    end
    if (state == S_CONV) begin
      acc <= acc_next;
      if (conv_last) begin
        col_reg <= to_rgb565(acc_next);
      end
    end
    if (state == S_EMIT && can_emit) begin
      out_action <= em_action;
      out_char   <= em_char;
      out_text   <= em_text;
      out_back   <= em_back;
      out_last   <= em_last;
    end
  end

endmodule

>>> test/color_tag_text_parser_tb.sv
// Self-checking testbench for the color tag text parser: predicted actions vs. DUT output.
module color_tag_text_parser_tb;
  import ctp_pkg::*;

  // Predictor sizes match the DUT defaults.
  localparam int STACK_SLOTS    = 16;
  localparam int DIGIT_LIMIT    = 6;
  localparam int HALF_PERIOD    = 6;
  localparam int RESET_CYCLES   = 5;
  // Idle time before a register write. A byte that makes no action can still be
  // in the DUT when the last expected action shows up.
  localparam int DRAIN_CYCLES   = 20;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PRINT_LIMIT    = 40;

  localparam logic [CHAR_W-1:0] CH_ZERO = "0";
  localparam logic [CHAR_W-1:0] CH_NINE = "9";
  localparam logic [CHAR_W-1:0] CH_LA   = "a";
  localparam logic [CHAR_W-1:0] CH_LF   = "f";
  localparam logic [CHAR_W-1:0] CH_UA   = "A";
  localparam logic [CHAR_W-1:0] CH_UF   = "F";

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              first;
    logic              markup;
  } text_byte_t;

  typedef struct packed {
    logic               action;
    logic [CHAR_W-1:0]  char_out;
    logic [COLOR_W-1:0] text_color;
    logic [COLOR_W-1:0] back_color;
    logic               last;
  } console_action_t;

  logic clk = 1'b0;
  logic rst;

  ctp_in_if  text_ch ();
  ctp_out_if result_ch ();
  ctp_cfg_if cfg_ch ();

  color_tag_text_parser i_dut (
    .clk    (clk),
    .rst    (rst),
    .text   (text_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // Stimulus and scoreboard storage.
  text_byte_t      pending_bytes[$];
  console_action_t expected_actions[$];
  text_byte_t      next_byte;
  int              queued_count    = 0;
  int              send_idle_pct   = 0;
  int              ready_stall_pct = 0;
  int              first_pct       = 0;
  int              fail_count      = 0;
  int              quiet_cycles    = 0;
  logic            byte_taken      = 1'b0;

  // Shadow copy of the parser: theme registers, tag state, color stack.
  logic [COLOR_W-1:0] theme_fg = FG_RESET;
  logic [COLOR_W-1:0] theme_bg = BG_RESET;
  logic               tag_open = 1'b0;
  logic               hash_open = 1'b0;
  int                 held_count = 0;
  logic [CHAR_W-1:0]  held_chars[DIGIT_LIMIT];
  logic [COLOR_W-1:0] stack_colors[STACK_SLOTS];
  int                 stack_fill = 0;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic int hex_nibble(logic [CHAR_W-1:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
    if (c >= CH_LA && c <= CH_LF) return int'(c - CH_LA) + 10;
    if (c >= CH_UA && c <= CH_UF) return int'(c - CH_UA) + 10;
    return -1;
  endfunction

  function automatic void emit_char(logic [CHAR_W-1:0] c);
    console_action_t a;
    a = '{ACT_CHAR, c, '0, '0, 1'b0};
    expected_actions.insert(expected_actions.size(), a);
  endfunction

  function automatic void emit_color(logic [COLOR_W-1:0] tc);
    console_action_t a;
    a = '{ACT_COLOR, '0, tc, theme_bg, 1'b0};
    expected_actions.insert(expected_actions.size(), a);
  endfunction

  function automatic void close_tag();
    tag_open   = 1'b0;
    hash_open  = 1'b0;
    held_count = 0;
  endfunction

  // Malformed color tag: give back "[", "#", the held digits and the offender.
  function automatic void echo_tag(logic [CHAR_W-1:0] offender);
    emit_char(CH_LBRACKET);
    emit_char(CH_HASH);
    for (int k = 0; k < held_count; k++) emit_char(held_chars[k]);
    emit_char(offender);
    close_tag();
  endfunction

  function automatic void predict_actions(text_byte_t t);
    int                 start;
    logic [RGB_W-1:0]   rgb;
    logic [COLOR_W-1:0] col;
    console_action_t    tail;
    start = expected_actions.size();
    if (!t.markup) begin
      // raw byte: drops any open tag and the whole stack, no color action
      close_tag();
      stack_fill = 0;
      emit_char(t.ch);
    end else begin
      if (t.first) begin
        close_tag();
        stack_fill = 0;
        emit_color(theme_fg);
      end
      if (!tag_open) begin
        if (t.ch == CH_LBRACKET) begin
          tag_open   = 1'b1;
          hash_open  = 1'b0;
          held_count = 0;
        end else begin
          emit_char(t.ch);
        end
      end else if (!hash_open) begin
        if (t.ch == CH_LBRACKET) begin
          // "[[" is an escaped bracket
          emit_char(CH_LBRACKET);
          close_tag();
        end else if (t.ch == CH_RBRACKET) begin
          // pop, then show the new top or the theme color
          if (stack_fill > 0) stack_fill--;
          emit_color(stack_fill > 0 ? stack_colors[stack_fill-1] : theme_fg);
          close_tag();
        end else if (t.ch == CH_HASH) begin
          hash_open  = 1'b1;
          held_count = 0;
        end else begin
          emit_char(CH_LBRACKET);
          emit_char(t.ch);
          close_tag();
        end
      end else if (t.ch == CH_LBRACKET) begin
        // stray bracket after the hash: skipped, tag stays open
      end else if (hex_nibble(t.ch) >= 0) begin
        if (held_count < DIGIT_LIMIT) begin
          held_chars[held_count] = t.ch;
          held_count++;
        end else begin
          echo_tag(t.ch);
        end
      end else if (t.ch == CH_RBRACKET) begin
        if (held_count == 0) begin
          // "[#]" resets to the theme color
          stack_fill = 0;
          emit_color(theme_fg);
        end else begin
          rgb = '0;
          for (int k = 0; k < held_count; k++)
            rgb = {rgb[RGB_W-NIB_W-1:0], 4'(hex_nibble(held_chars[k]))};
          // top 5/6/5 bits of R/G/B
          col = {rgb[23:19], rgb[15:10], rgb[7:3]};
          emit_color(col);
          if (stack_fill >= STACK_SLOTS) begin
            // full: oldest entry falls off the bottom
            for (int k = 0; k < STACK_SLOTS - 1; k++) stack_colors[k] = stack_colors[k+1];
            stack_fill = STACK_SLOTS - 1;
          end
          stack_colors[stack_fill] = col;
          stack_fill++;
        end
        close_tag();
      end else begin
        echo_tag(t.ch);
      end
    end
    if (expected_actions.size() > start) begin
      tail      = expected_actions[expected_actions.size()-1];
      tail.last = 1'b1;
      expected_actions[expected_actions.size()-1] = tail;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------
  function automatic void add_byte(logic [CHAR_W-1:0] c, logic f, logic m);
    text_byte_t b;
    b = '{c, f, m};
    pending_bytes.insert(pending_bytes.size(), b);
    queued_count++;
  endfunction

  // markup byte, occasionally flagged as start of text
  function automatic void add_text(logic [CHAR_W-1:0] c);
    add_byte(c, $urandom_range(99) < first_pct, 1'b1);
  endfunction

  function automatic void add_digits(int n);
    logic [3:0] nib;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(9) == 0) add_text(CH_LBRACKET);
      nib = 4'($urandom_range(15));
      if (nib < 4'd10) add_text(CH_ZERO + CHAR_W'(nib));
      else add_text(($urandom_range(1) ? CH_LA : CH_UA) + CHAR_W'(nib) - CHAR_W'(10));
    end
  endfunction

  // One well-formed or broken tag, plain text, raw bytes or noise.
  // Deep mode is push heavy with short colors so the stack overflows.
  function automatic void add_random_fragment(bit deep);
    int                roll;
    logic [CHAR_W-1:0] c;
    roll = $urandom_range(99);
    if (deep) begin
      if (roll < 80) begin
        add_text(CH_LBRACKET);
        add_text(CH_HASH);
        add_digits($urandom_range(1, 2));
        add_text(CH_RBRACKET);
      end else if (roll < 85) begin
        add_text(CH_LBRACKET);
        add_text(CH_RBRACKET);
      end else begin
        add_text(CHAR_W'($urandom_range(255)));
      end
    end else if (roll < 30) begin
      add_text(CHAR_W'($urandom_range(255)));
    end else if (roll < 45) begin
      add_text(CH_LBRACKET);
      add_text(CH_HASH);
      add_digits($urandom_range(1, DIGIT_LIMIT));
      add_text(CH_RBRACKET);
    end else if (roll < 55) begin
      add_text(CH_LBRACKET);
      add_text(CH_RBRACKET);
    end else if (roll < 60) begin
      add_text(CH_LBRACKET);
      add_text(CH_HASH);
      add_text(CH_RBRACKET);
    end else if (roll < 65) begin
      add_text(CH_LBRACKET);
      add_text(CH_LBRACKET);
    end else if (roll < 70) begin
      // bracket followed by something that is not a tag
      do c = CHAR_W'($urandom_range(255));
      while (c == CH_HASH || c == CH_LBRACKET || c == CH_RBRACKET);
      add_text(CH_LBRACKET);
      add_text(c);
    end else if (roll < 77) begin
      // one digit too many
      add_text(CH_LBRACKET);
      add_text(CH_HASH);
      add_digits(DIGIT_LIMIT + 1);
    end else if (roll < 85) begin
      // non-hex byte inside a color
      do c = CHAR_W'($urandom_range(255));
      while (hex_nibble(c) >= 0 || c == CH_LBRACKET || c == CH_RBRACKET);
      add_text(CH_LBRACKET);
      add_text(CH_HASH);
      add_digits($urandom_range(0, DIGIT_LIMIT));
      add_text(c);
    end else if (roll < 93) begin
      // raw bytes, sometimes cutting into an open tag
      if ($urandom_range(1)) begin
        add_text(CH_LBRACKET);
        if ($urandom_range(1)) begin
          add_text(CH_HASH);
          add_digits($urandom_range(0, 3));
        end
      end
      repeat ($urandom_range(1, 2))
        add_byte(CHAR_W'($urandom_range(255)), 1'($urandom_range(1)), 1'b0);
    end else begin
      add_byte(CHAR_W'($urandom_range(255)), $urandom_range(9) == 0, $urandom_range(4) != 0);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: text bytes and result ready, updated on the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      text_ch.valid   <= 1'b0;
      result_ch.ready <= 1'b0;
    end else begin
      if (!text_ch.valid || byte_taken) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_byte = pending_bytes.pop_front();
          text_ch.valid  <= 1'b1;
          text_ch.ch     <= next_byte.ch;
          text_ch.first  <= next_byte.first;
          text_ch.markup <= next_byte.markup;
        end else begin
          text_ch.valid <= 1'b0;
        end
      end
      result_ch.ready <= $urandom_range(99) >= ready_stall_pct;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor and scoreboard, sampled on the rising edge
  // ---------------------------------------------------------------------------
  function automatic void report_field(string field, logic [COLOR_W-1:0] want,
                                       logic [COLOR_W-1:0] got);
    if (want != got) begin
      fail_count++;
      if (fail_count <= PRINT_LIMIT)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    end
  endfunction

  always @(posedge clk) begin
    console_action_t want;
    byte_taken <= text_ch.valid && text_ch.ready;
    if (!rst) begin
      // theme writes only land while nothing is in flight
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == REG_FOREGROUND) theme_fg = cfg_ch.data;
        else theme_bg = cfg_ch.data;
      end
      if (text_ch.valid && text_ch.ready)
        predict_actions('{text_ch.ch, text_ch.first, text_ch.markup});
      if (result_ch.valid && result_ch.ready) begin
        if (expected_actions.size() == 0) begin
          fail_count++;
          if (fail_count <= PRINT_LIMIT)
            $display("%0t: unexpected action, expected none, actual %0h/%02h/%04h/%04h/%0h",
                     $time, result_ch.action, result_ch.char_out, result_ch.text_color,
                     result_ch.back_color, result_ch.last);
        end else begin
          want = expected_actions.pop_front();
          report_field("action", COLOR_W'(want.action), COLOR_W'(result_ch.action));
          report_field("char_out", COLOR_W'(want.char_out), COLOR_W'(result_ch.char_out));
          report_field("text_color", want.text_color, result_ch.text_color);
          report_field("back_color", want.back_color, result_ch.back_color);
          report_field("last", COLOR_W'(want.last), COLOR_W'(result_ch.last));
        end
      end
    end
  end

  // Watchdog: too long without any transaction on any channel.
  always @(posedge clk) begin
    if (rst || (text_ch.valid && text_ch.ready) || (result_ch.valid && result_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencing
  // ---------------------------------------------------------------------------
  task automatic write_theme(input logic [COLOR_W-1:0] fg, input logic [COLOR_W-1:0] bg);
    for (int r = 0; r < 2; r++) begin
      @(negedge clk);
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= r ? REG_BACKGROUND : REG_FOREGROUND;
      cfg_ch.data  <= r ? bg : fg;
      do @(posedge clk); while (!cfg_ch.ready);
      @(negedge clk) cfg_ch.valid <= 1'b0;
    end
    // leave on a rising edge so queue updates never race the driver
    @(posedge clk);
  endtask

  // Queue random traffic, then wait for every byte and action to clear.
  task automatic run_phase(input int idle_pct, input int stall_pct, input int n_items,
                           input bit deep);
    send_idle_pct   = idle_pct;
    ready_stall_pct = stall_pct;
    first_pct       = deep ? 0 : 4;
    queued_count    = 0;
    while (queued_count < n_items) add_random_fragment(deep);
    while (pending_bytes.size() != 0 || text_ch.valid || expected_actions.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin
    string directed_text;
    // push a short color, pop to theme, pop on empty, escaped bracket,
    // bracket without hash, skipped bracket plus bad digit, reset tag
    directed_text = "[#fF][][][[[a[#[1g[#]";
    rst              = 1'b1;
    text_ch.valid    = 1'b0;
    text_ch.ch       = '0;
    text_ch.first    = 1'b0;
    text_ch.markup   = 1'b0;
    result_ch.ready  = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = REG_FOREGROUND;
    cfg_ch.data      = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Directed: theme at the opposite extremes of reset.
    write_theme(16'h0000, 16'hFFFF);
    add_byte("A", 1'b1, 1'b1);             // start of text: color reset then "A"
    add_byte(8'hFF, 1'b1, 1'b0);           // raw start of text: no color action
    for (int i = 0; i < directed_text.len(); i++) add_byte(directed_text[i], 1'b0, 1'b1);
    add_byte(8'h00, 1'b0, 1'b1);
    run_phase(0, 0, 0, 1'b0);

    // Random phases, each with its own theme and idling pattern.
    write_theme(16'hFFFF, 16'h0000);
    run_phase(0, 0, 70, 1'b0);
    write_theme(COLOR_W'($urandom_range(16'hFFFF)), COLOR_W'($urandom_range(16'hFFFF)));
    run_phase(76, 0, 110, 1'b1);
    write_theme(COLOR_W'($urandom_range(16'hFFFF)), COLOR_W'($urandom_range(16'hFFFF)));
    run_phase(0, 76, 70, 1'b0);
    write_theme(COLOR_W'($urandom_range(16'hFFFF)), COLOR_W'($urandom_range(16'hFFFF)));
    run_phase(36, 36, 70, 1'b0);

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
